// ===== src/petc_pkg.sv =====
`default_nettype none
package petc_pkg;
    localparam int COORD_BITS = 24;
    localparam int MAX_VERTS  = 4;
    localparam int REG_BITS   = 31;
    localparam int LEN_BITS   = 26;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS + 2;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 1'b1;
    localparam int OUT_BITS   = 32;
    localparam int DIVQ_BITS  = 51;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } vertex_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] tex_u1;
        logic [OUT_BITS-1:0] tex_u2;
        logic [OUT_BITS-1:0] tex_v2;
        logic [OUT_BITS-1:0] tex_v3;
        logic                is_quad;
        logic                bad_count;
    } result_t;

    typedef struct packed {
        vertex_t pos;
        logic    last_vertex;
    } vert_item_t;
endpackage
`default_nettype wire

// ===== src/petc_if.sv =====
`default_nettype none
interface petc_vert_if;
    logic valid;
    logic ready;
    petc_pkg::vert_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface petc_res_if;
    logic valid;
    logic ready;
    petc_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/petc_isqrt.sv =====
`default_nettype none
// Bit-serial integer square root: one result bit per cycle.
module petc_isqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [petc_pkg::SQ_BITS-1:0]    radicand,
    output logic                                 done,
    output logic [petc_pkg::LEN_BITS-1:0]        root
);
    localparam int STEPS = petc_pkg::SQ_BITS / 2;
    localparam int CNT_BITS = $clog2(STEPS + 1);

    logic [petc_pkg::SQ_BITS-1:0]  rad_reg;
    logic [petc_pkg::LEN_BITS+1:0] rem_reg;
    logic [petc_pkg::LEN_BITS-1:0] root_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [petc_pkg::LEN_BITS+1:0] rem_sh;
    logic [petc_pkg::LEN_BITS+1:0] trial;

    // One restoring step on the next pair of radicand bits.
    always_comb
    begin
        rem_sh = {rem_reg[petc_pkg::LEN_BITS-1:0], rad_reg[petc_pkg::SQ_BITS-1 -: 2]};
        trial  = {root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(STEPS);
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg <= rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[petc_pkg::LEN_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[petc_pkg::LEN_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== src/petc_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
module petc_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [petc_pkg::LEN_BITS-1:0]    len,
    input  wire logic [petc_pkg::REG_BITS-1:0]    divisor,
    output logic                                  done,
    output logic [petc_pkg::OUT_BITS-1:0]         quot
);
    localparam int N = petc_pkg::DIVQ_BITS - 1;
    localparam int CNT_BITS = $clog2(petc_pkg::DIVQ_BITS + 1);

    logic [N-1:0]                     num_reg;
    logic [petc_pkg::REG_BITS:0]      rem_reg;
    logic [N-1:0]                     q_reg;
    logic [petc_pkg::REG_BITS-1:0]    dv_reg;
    logic [CNT_BITS-1:0]              cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [petc_pkg::REG_BITS:0]      rem_sh;

    always_comb
    begin
        rem_sh = {rem_reg[petc_pkg::REG_BITS-1:0], num_reg[N-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(N);
                num_reg  <= {len, 24'd0};
                rem_reg  <= '0;
                q_reg    <= '0;
                dv_reg   <= divisor;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                if (rem_sh >= {1'b0, dv_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, dv_reg};
                    q_reg   <= {q_reg[N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[N-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Zero divisor and overflow both saturate.
    always_comb
    begin
        if (dv_reg == '0 || q_reg[N-1:petc_pkg::OUT_BITS] != '0)
            quot = '1;
        else
            quot = q_reg[petc_pkg::OUT_BITS-1:0];
    end
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== src/polygon_edge_texture_coords_core.sv =====
`default_nettype none
// Channel   Direction  Payload
// vert_in   sink       pos_x, pos_y, pos_z, last_vertex
// res_out   source     tex_u1, tex_u2, tex_v2, tex_v3, is_quad, bad_count
// cfg       write      cfg_we, cfg_index, cfg_data
//
// A middle vertex that closes an edge squares and sums the three deltas (S_SQ, S_SUM per
// axis), then takes the bit-serial root of 26 steps before ready rises again. A vertex with
// no edge to store leaves the sequencer in S_IDLE. A closing vertex needs two such roots and
// one division per coordinate on one shared divider, then S_OUT raises the result valid;
// a bad vertex count gives its result on the next cycle. Reset is asynchronous; it clears
// control state and the first and previous vertex, and loads 65536 into width and height.
// While a result waits on res_out the block accepts no new vertex.
module polygon_edge_texture_coords_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    petc_vert_if.sink                                 vert_in,
    petc_res_if.source                                res_out,
    input  wire logic                                 cfg_we,
    input  wire logic [petc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [petc_pkg::REG_BITS-1:0]        cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SUM, S_ROOT, S_ROOT_WAIT, S_DIV, S_DIV_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [petc_pkg::REG_BITS-1:0] width_reg, height_reg;
    petc_pkg::vertex_t first_reg, prev_reg, cur_reg;
    petc_pkg::vertex_t pa_reg, pb_reg;
    logic [2:0] count_reg;
    logic [petc_pkg::LEN_BITS-1:0] edge_reg [3];
    logic last_reg;
    logic quad_reg;
    logic [1:0] root_idx_reg;
    logic [1:0] axis_reg;
    logic [2:0] div_idx_reg;
    logic [petc_pkg::SQ_BITS-1:0] sum_reg;
    logic [petc_pkg::DIFF_BITS-1:0] diff_reg;
    logic [petc_pkg::LEN_BITS-1:0] d1_reg, d2_reg, d3_reg;
    petc_pkg::result_t res_reg;
    logic out_valid_reg;

    logic sq_start, sq_done, dv_start, dv_done;
    logic [petc_pkg::LEN_BITS-1:0] root;
    logic [petc_pkg::OUT_BITS-1:0] quot;
    logic [petc_pkg::LEN_BITS-1:0] div_len;
    logic [petc_pkg::REG_BITS-1:0] div_reg;
    logic signed [petc_pkg::DIFF_BITS-1:0] delta;
    logic [petc_pkg::COORD_BITS-1:0] ca, cb;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= petc_pkg::REG_BITS'(65536);
            height_reg <= petc_pkg::REG_BITS'(65536);
        end
        else if (cfg_we)
        begin
            if (cfg_index == petc_pkg::CFG_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == petc_pkg::CFG_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // Axis selection for the delta of the current edge.
    always_comb
    begin
        case (axis_reg)
            2'd0:    begin ca = pa_reg.x; cb = pb_reg.x; end
            2'd1:    begin ca = pa_reg.y; cb = pb_reg.y; end
            default: begin ca = pa_reg.z; cb = pb_reg.z; end
        endcase
        delta = $signed({ca[petc_pkg::COORD_BITS-1], ca}) -
                $signed({cb[petc_pkg::COORD_BITS-1], cb});
    end

    // Divide job table: u1, u2, v2, v3.
    always_comb
    begin
        case (div_idx_reg)
            3'd0:    begin div_len = edge_reg[0]; div_reg = width_reg;  end
            3'd1:    begin div_len = d2_reg;      div_reg = width_reg;  end
            3'd2:    begin div_len = d1_reg;      div_reg = height_reg; end
            default: begin div_len = d3_reg;      div_reg = height_reg; end
        endcase
    end

    assign sq_start = (state_reg == S_ROOT);
    assign dv_start = (state_reg == S_DIV);
    assign vert_in.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign res_out.valid = out_valid_reg;
    assign res_out.data  = res_reg;

    petc_isqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_reg),
        .done(sq_done), .root(root)
    );
    petc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .len(div_len),
        .divisor(div_reg), .done(dv_done), .quot(quot)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && res_out.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (vert_in.valid && vert_in.ready)
                    begin
                        cur_reg  <= vert_in.data.pos;
                        last_reg <= vert_in.data.last_vertex;
                        pa_reg   <= prev_reg;
                        pb_reg   <= vert_in.data.pos;
                        axis_reg <= '0;
                        sum_reg  <= '0;
                        root_idx_reg <= '0;
                        div_idx_reg  <= '0;
                        quad_reg <= (count_reg == 3'd3) && (petc_pkg::MAX_VERTS >= 4);
                        if (vert_in.data.last_vertex)
                        begin
                            count_reg <= '0;
                            if (count_reg != 3'd2 &&
                                !(count_reg == 3'd3 && petc_pkg::MAX_VERTS >= 4))
                            begin
                                // Zero coordinates with only the bad count flag set.
                                res_reg <= {{(4 * petc_pkg::OUT_BITS + 1){1'b0}}, 1'b1};
                                out_valid_reg <= 1'b1;
                            end
                            else
                                state_reg <= S_SQ;
                        end
                        else
                        begin
                            if (count_reg == 3'd0)
                                first_reg <= vert_in.data.pos;
                            else if (count_reg < 3'd4)
                                state_reg <= S_SQ;
                            prev_reg <= vert_in.data.pos;
                            if (count_reg != 3'd7)
                                count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                S_SQ:
                begin
                    diff_reg <= delta[petc_pkg::DIFF_BITS-1] ?
                                petc_pkg::DIFF_BITS'(-delta) : delta;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sum_reg <= sum_reg + petc_pkg::SQ_BITS'(diff_reg * diff_reg);
                    if (axis_reg == 2'd2)
                        state_reg <= S_ROOT;
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_ROOT:
                    state_reg <= S_ROOT_WAIT;
                S_ROOT_WAIT:
                begin
                    if (sq_done)
                    begin
                        if (!last_reg)
                        begin
                            edge_reg[2'(count_reg - 3'd2)] <= root;
                            state_reg <= S_IDLE;
                        end
                        else if (root_idx_reg == 2'd0)
                        begin
                            if (quad_reg) d2_reg <= root;
                            else          d1_reg <= root;
                            root_idx_reg <= 2'd1;
                            pa_reg   <= cur_reg;
                            pb_reg   <= first_reg;
                            axis_reg <= '0;
                            sum_reg  <= '0;
                            state_reg <= S_SQ;
                        end
                        else
                        begin
                            if (quad_reg)
                            begin
                                d3_reg <= root;
                                d1_reg <= edge_reg[1];
                            end
                            else
                            begin
                                d2_reg <= root;
                                d3_reg <= '0;
                            end
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (dv_done)
                    begin
                        case (div_idx_reg)
                            3'd0:    res_reg.tex_u1 <= quot;
                            3'd1:    res_reg.tex_u2 <= quot;
                            3'd2:    res_reg.tex_v2 <= quot;
                            default: res_reg.tex_v3 <= quot;
                        endcase
                        if (div_idx_reg == 3'd3 || (div_idx_reg == 3'd2 && !quad_reg))
                        begin
                            if (!quad_reg)
                                res_reg.tex_v3 <= '0;
                            res_reg.is_quad   <= quad_reg;
                            res_reg.bad_count <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            div_idx_reg <= div_idx_reg + 1'b1;
                            state_reg   <= S_DIV;
                        end
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // A result is never presented while the sequencer is working.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_IDLE))
        else $error("result valid while busy");
    // A bad count result carries zero coordinates; the property checks tex_u1 and is_quad.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.bad_count) |-> (res_reg.tex_u1 == '0 && !res_reg.is_quad))
        else $error("bad count result not cleared");
    // Vertex count returns to zero after a closing vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        (vert_in.valid && vert_in.ready && vert_in.data.last_vertex) |=> (count_reg == '0))
        else $error("count not reset");
endmodule
`default_nettype wire
